// ===== rtl/core/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants and types for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int MaxBoxesDef  = 64;
   localparam int CoordBitsDef = 16;
   localparam int ScoreBitsDef = 16;
   localparam int ThrBits      = 16;
   localparam logic [ThrBits-1:0] ThrReset = 16'h8000;

   // controller -> datapath
   typedef struct packed {
      logic load;       // store input word
      logic clr_count;  // end of set
      logic arm;        // set alive mask from count
      logic scan_start; // reset running best
      logic scan_step;  // compare entry at index
      logic keep;       // take best, clear its alive bit
      logic iou_rd;     // address entry for iou test
      logic iou_chk;    // test entry read last cycle
      logic [6:0] idx;  // scan index
   } gbs_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       any_alive;
      logic [6:0] count;
      logic       full;
   } gbs_sts_type;

endpackage

// ===== rtl/core/gbs_ram.sv =====
// ----------------------------------------------------------------------------
// gbs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gbs_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/gbs_datapath.sv =====
// ----------------------------------------------------------------------------
// gbs_datapath
// Box/score/area stores, alive mask, best search and IoU test pipeline.
// ----------------------------------------------------------------------------
module gbs_datapath #(
   parameter int MaxBoxes  = 64,
   parameter int CoordBits = 16,
   parameter int ScoreBits = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gbs_pkg::gbs_cmd_type        cmd,
   output gbs_pkg::gbs_sts_type        sts,
   input  logic [CoordBits-1:0]        in_x1,
   input  logic [CoordBits-1:0]        in_y1,
   input  logic [CoordBits-1:0]        in_x2,
   input  logic [CoordBits-1:0]        in_y2,
   input  logic [ScoreBits-1:0]        in_score,
   input  logic [gbs_pkg::ThrBits-1:0] thr,
   output logic [5:0]                  kept_idx
);
   import gbs_pkg::*;

   localparam int AW = $clog2(MaxBoxes);
   localparam int BW = 4 * CoordBits;
   localparam int RW = BW + ScoreBits;
   localparam int AR = 2 * CoordBits;
   localparam int PW = AR + ThrBits + 1;

   function automatic logic [CoordBits-1:0] span(input logic [CoordBits-1:0] lo,
                                                 input logic [CoordBits-1:0] hi);
      span = (hi > lo) ? hi - lo : '0;
   endfunction

   logic [6:0]          count_ff, count_in;
   logic [MaxBoxes-1:0] alive_ff, alive_in;
   logic [AW-1:0]       best_ff, best_in;
   logic [ScoreBits-1:0] bscore_ff, bscore_in;
   logic                found_ff, found_in;
   logic [BW-1:0]       kbox_ff;
   logic [AR-1:0]       karea_ff;

   logic [AW-1:0] wa, ra;
   logic [RW-1:0] rd_rec;
   logic [AR-1:0] rd_area;
   logic [CoordBits-1:0] w_x, w_y;
   logic [AR-1:0]  new_area;

   assign w_x = span(in_x1, in_x2);
   assign w_y = span(in_y1, in_y2);
   assign new_area = AR'(w_x) * AR'(w_y);
   assign wa = count_ff[AW-1:0];
   // keep cycle reads the best entry back for the iou reference
   assign ra = cmd.keep ? best_ff : cmd.idx[AW-1:0];

   gbs_ram #(.Width(RW), .Depth(MaxBoxes)) u_rec (
      .clock, .wr_en(cmd.load && !sts.full), .wr_addr(wa),
      .wr_data({in_score, in_y2, in_x2, in_y1, in_x1}),
      .rd_addr(ra), .rd_data(rd_rec));
   gbs_ram #(.Width(AR), .Depth(MaxBoxes)) u_area (
      .clock, .wr_en(cmd.load && !sts.full), .wr_addr(wa),
      .wr_data(new_area), .rd_addr(ra), .rd_data(rd_area));

   // read data belongs to index of the previous cycle
   logic [AW-1:0] ridx_ff;
   logic          rval_ff;
   always_ff @(posedge clock) begin
      ridx_ff <= ra;
      rval_ff <= (cmd.scan_step || cmd.iou_rd) && (cmd.idx < count_ff);
   end

   logic [CoordBits-1:0] bx1, by1, bx2, by2, rx1, ry1, rx2, ry2, iw, ih;
   logic [ScoreBits-1:0] rscore;
   assign {rscore, ry2, rx2, ry1, rx1} = rd_rec;
   assign {by2, bx2, by1, bx1} = kbox_ff;
   assign iw = span((rx1 > bx1) ? rx1 : bx1, (rx2 < bx2) ? rx2 : bx2);
   assign ih = span((ry1 > by1) ? ry1 : by1, (ry2 < by2) ? ry2 : by2);

   // iou stage 1: intersection and area sum
   logic [AR-1:0] inter_ff;
   logic [AR:0]   asum_ff;
   logic [AW-1:0] s1_idx_ff;
   logic          s1_ff;
   // iou stage 2: products
   logic [PW-1:0] lhs_ff, rhs_ff;
   logic [AW-1:0] s2_idx_ff;
   logic          s2_ff;

   always_ff @(posedge clock) begin
      inter_ff  <= AR'(iw) * AR'(ih);
      asum_ff   <= {1'b0, rd_area} + {1'b0, karea_ff};
      s1_idx_ff <= ridx_ff;
      lhs_ff    <= {1'b0, inter_ff, {ThrBits{1'b0}}};
      rhs_ff    <= PW'(thr) * PW'(asum_ff - {1'b0, inter_ff});
      s2_idx_ff <= s1_idx_ff;
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.iou_chk && rval_ff;
         s2_ff <= s1_ff;
      end
   end

   always_comb begin
      count_in  = count_ff;
      alive_in  = alive_ff;
      best_in   = best_ff;
      bscore_in = bscore_ff;
      found_in  = found_ff;
      if (cmd.load && !sts.full) count_in = count_ff + 7'd1;
      if (cmd.clr_count) begin
         count_in = '0;
         alive_in = '0;
      end
      if (cmd.arm) begin
         for (int i = 0; i < MaxBoxes; i++) alive_in[i] = (7'(i) < count_ff);
      end
      if (cmd.scan_start) found_in = 1'b0;
      // scan_step issues a read; compare happens when data returns
      if (rval_ff && !cmd.iou_chk && alive_ff[ridx_ff] &&
          (!found_ff || rscore > bscore_ff)) begin
         found_in  = 1'b1;
         best_in   = ridx_ff;
         bscore_in = rscore;
      end
      if (cmd.keep) alive_in[best_ff] = 1'b0;
      if (s2_ff && lhs_ff > rhs_ff) alive_in[s2_idx_ff] = 1'b0;
   end

   // capture kept box when its record returns (keep issued read of best)
   logic cap_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         alive_ff <= '0;
         found_ff <= 1'b0;
         cap_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         alive_ff <= alive_in;
         found_ff <= found_in;
         cap_ff   <= cmd.keep;
      end
      best_ff   <= best_in;
      bscore_ff <= bscore_in;
      if (cap_ff) begin
         kbox_ff  <= rd_rec[BW-1:0];
         karea_ff <= rd_area;
      end
   end

   assign sts.any_alive = |alive_ff;
   assign sts.count     = count_ff;
   assign sts.full      = (count_ff >= 7'(MaxBoxes));
   assign kept_idx      = 6'(best_ff);
endmodule

// ===== rtl/core/gbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: load, best scan, keep, IoU sweep, drain, emit, repeat.
// ----------------------------------------------------------------------------
module gbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_last,
   output logic                 in_ready,
   output logic                 out_valid,
   output logic                 out_last,
   input  logic                 out_ready,
   output gbs_pkg::gbs_cmd_type cmd,
   input  gbs_pkg::gbs_sts_type sts
);
   import gbs_pkg::*;

   typedef enum logic [2:0] {
      LOAD, ARM, SCAN, KEEP, IOU, DRAIN, EMIT
   } state_type;

   state_type  state_ff;
   logic [6:0] idx_ff;
   logic       ov_ff, ol_ff;

   // scan: issue idx 0..count-1, then wait for the last data
   // iou: issue idx 0..count-1 once the kept box is captured, then drain
   always_comb begin
      cmd = '0;
      cmd.idx = idx_ff;
      cmd.load = (state_ff == LOAD) && in_valid;
      case (state_ff)
         LOAD: cmd.arm = 1'b0;
         ARM: begin
            cmd.arm = 1'b1;
            cmd.scan_start = 1'b1;
         end
         SCAN: cmd.scan_step = (idx_ff < sts.count);
         KEEP: cmd.keep = 1'b1;
         IOU: begin
            cmd.iou_rd  = 1'b1;
            cmd.iou_chk = 1'b1;
         end
         DRAIN: cmd.iou_chk = 1'b1;
         EMIT: begin
            cmd.scan_start = 1'b1;
            cmd.clr_count  = out_ready && !sts.any_alive;
         end
         default: cmd.arm = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
         idx_ff   <= '0;
         ov_ff    <= 1'b0;
         ol_ff    <= 1'b0;
      end else begin
         case (state_ff)
            LOAD: if (in_valid && in_last) state_ff <= ARM;
            ARM: begin
               idx_ff   <= '0;
               state_ff <= SCAN;
            end
            SCAN: begin
               idx_ff <= idx_ff + 7'd1;
               if (idx_ff >= sts.count) state_ff <= KEEP;
            end
            KEEP: begin
               idx_ff   <= 7'h7f;
               state_ff <= IOU;
            end
            IOU: begin
               idx_ff <= idx_ff + 7'd1;
               if (idx_ff == sts.count) begin
                  idx_ff   <= '0;
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               idx_ff <= idx_ff + 7'd1;
               if (idx_ff == 7'd3) begin
                  ov_ff    <= 1'b1;
                  ol_ff    <= !sts.any_alive;
                  state_ff <= EMIT;
               end
            end
            EMIT: if (out_ready) begin
               ov_ff  <= 1'b0;
               idx_ff <= '0;
               state_ff <= sts.any_alive ? SCAN : LOAD;
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   assign in_ready  = (state_ff == LOAD);
   assign out_valid = ov_ff;
   assign out_last  = ol_ff;
endmodule

// ===== rtl/core/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression by IoU over a set of loaded boxes.
// ----------------------------------------------------------------------------
// Usage: boxes arrive on req_ one word each; req_tlast marks the last box of a
// set and starts suppression. Words beyond MaxBoxes are dropped, tlast still
// acts. Results leave on rsp_: tdata is the kept load index, highest score
// first (ties: lower index), rsp_tlast on the final kept index.
// Loading accepts one box per cycle while req_tready is high. Each kept box
// costs one scan of N reads, a keep step, one IoU sweep of N tests, a
// pipeline drain and an emit step; scan and sweep run one read at a time on
// the single read port of the box store.
// No input is taken during suppression. A stalled rsp_tready holds the
// current result and delays the next scan. Reset empties the set, clears the
// alive mask and sets csr threshold to 0.5 (Q0.16); the stores need no
// clearing.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
   parameter int MaxBoxes  = gbs_pkg::MaxBoxesDef,
   parameter int CoordBits = gbs_pkg::CoordBitsDef,
   parameter int ScoreBits = gbs_pkg::ScoreBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // box_x1, box_y1, box_x2, box_y2, box_score
   input  logic [((4*CoordBits+ScoreBits+7)/8)*8-1:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // kept_index, zero fill
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [gbs_pkg::ThrBits-1:0] csr_wr_data
);
   import gbs_pkg::*;

   gbs_cmd_type cmd;
   gbs_sts_type sts;
   logic [ThrBits-1:0] thr_ff;
   logic [5:0] kidx;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= ThrReset;
      else if (csr_wr_en) thr_ff <= csr_wr_data;
   end

   gbs_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_last(req_tlast),
      .in_ready(req_tready), .out_valid(rsp_tvalid), .out_last(rsp_tlast),
      .out_ready(rsp_tready), .cmd, .sts);

   gbs_datapath #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits),
                  .ScoreBits(ScoreBits)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_x1(req_tdata[0 +: CoordBits]),
      .in_y1(req_tdata[CoordBits +: CoordBits]),
      .in_x2(req_tdata[2*CoordBits +: CoordBits]),
      .in_y2(req_tdata[3*CoordBits +: CoordBits]),
      .in_score(req_tdata[4*CoordBits +: ScoreBits]),
      .thr(thr_ff), .kept_idx(kidx));

   assign rsp_tdata = {2'b00, kidx};
endmodule
